// ===== hw/rtl/sglb_pkg.sv =====
// ---------------------------------------------------------------------------
// Signed gcd/lcm/Bezout package
// Shared types and constants for the controller, datapath and top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sglb_pkg;

  localparam int OpW  = 32;
  localparam int WideW = 64;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,       // capture operands
    OP_GCD_INIT,   // order magnitudes for Euclid
    OP_GCD_DIV,    // start x / y
    OP_GCD_STEP,   // x <- y, y <- remainder
    OP_SIGN_G,     // apply sign to gcd, start |a| / |g|
    OP_AN_DONE,    // capture a/g, start |b| / |g|
    OP_BN_DONE,    // capture b/g
    OP_LCM_MUL,    // a * (b/g), pick modulus and operands for the inverse
    OP_LCM_DONE,   // capture lcm
    OP_COEF_EASY,  // modulus 0 or 1: no inverse needed
    OP_RED_START,  // start reduction of the inverted operand
    OP_RED_DONE,   // set up remainder and coefficient chains
    OP_INV_DIV,    // start r0 / r1
    OP_INV_MUL,    // advance remainders, form q * t1
    OP_INV_STEP,   // advance coefficients
    OP_INV_FIX,    // bring t0 into [0, m)
    OP_COEF_MUL,   // c * searched operand
    OP_COEF_DIV,   // start (1 - c*n) / d
    OP_COEF_DONE,  // capture the other coefficient
    OP_FINISH      // assemble result
  } dp_op_t;

  typedef struct packed {
    logic   y_zero;    // Euclid remainder chain finished
    logic   r1_zero;   // inverse remainder chain finished
    logic   div_busy;  // divider working
    logic   both_zero; // both operands zero
    logic   m_small;   // modulus is 0 or 1
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sglb_if.sv =====
// ---------------------------------------------------------------------------
// Valid/ready stream interfaces
// One carries the operand pair, the other the result, each between a source and a sink.
// ---------------------------------------------------------------------------
`default_nettype none

interface sglb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sglb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gcd_value;
  logic signed [63:0] lcm_value;
  logic signed [31:0] alpha;
  logic signed [31:0] beta;
  logic               zero_error;
  modport source (output valid, output gcd_value, output lcm_value, output alpha,
                  output beta, output zero_error, input ready);
  modport sink   (input valid, input gcd_value, input lcm_value, input alpha,
                  input beta, input zero_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sglb_div.sv =====
// ---------------------------------------------------------------------------
// Radix-2 unsigned divider
// Restoring division of a 64-bit dividend by a 64-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sglb_div
  import sglb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WideW-1:0] dividend,
  input  wire logic [WideW-1:0] divisor,
  output logic                  busy,
  output logic [WideW-1:0]      quotient,
  output logic [WideW-1:0]      remainder
);

  logic [6:0]       cnt_r;
  logic [WideW-1:0] q_r, rem_r, d_r;
  logic [WideW:0]   trial;
  logic [WideW:0]   shifted;

  assign shifted = {rem_r, q_r[WideW-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'(WideW);
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 7'd1;
      if (!trial[WideW]) begin
        rem_r <= trial[WideW-1:0];
        q_r   <= {q_r[WideW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[WideW-1:0];
        q_r   <= {q_r[WideW-2:0], 1'b0};
      end
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sglb_dp.sv =====
// ---------------------------------------------------------------------------
// Gcd/lcm/Bezout datapath
// Operand registers, shared divider and multiplier driven by controller ops.
// ---------------------------------------------------------------------------
`default_nettype none

module sglb_dp
  import sglb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_op_t             op,
  input  wire logic signed [31:0] in_a,
  input  wire logic signed [31:0] in_b,
  output dp_status_t              status,
  output logic signed [31:0]      res_g,
  output logic signed [63:0]      res_lcm,
  output logic signed [31:0]      res_alpha,
  output logic signed [31:0]      res_beta,
  output logic                    res_zero
);

  function automatic logic [WideW-1:0] mag64(input logic signed [WideW-1:0] v);
    return v[WideW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  logic signed [WideW-1:0] a_r, b_r, g_r, an_r, bn_r, ns_r, nd_r, lcm_r;
  logic signed [WideW-1:0] t0_r, t1_r, prod_r, c_r, o_r;
  logic [WideW-1:0]        x_r, y_r, m_r, r0_r, r1_r;
  logic                    sel_b_r;    // true when |a| <= |b|: search beta
  logic                    one_zero_r; // one operand is zero: gcd stays positive
  logic                    zero_r;
  logic                    neg_r;
  logic signed [OpW-1:0]   g_out_r, alpha_out_r, beta_out_r;
  logic signed [WideW-1:0] lcm_out_r;

  logic [WideW-1:0]        ma, mb, man, mbn, mt1, mns, mnd, mone;
  logic                    gneg;
  logic signed [WideW-1:0] one_minus, sq, mul_s;

  logic             div_start, div_busy, div_neg;
  logic [WideW-1:0] div_n, div_d, div_q, div_r;

  logic [OpW-1:0]   mul_x, mul_y;
  logic             mul_neg;
  logic [WideW-1:0] mul_p;

  assign ma        = mag64(a_r);
  assign mb        = mag64(b_r);
  assign man       = mag64(an_r);
  assign mbn       = mag64(bn_r);
  assign mt1       = mag64(t1_r);
  assign mns       = mag64(ns_r);
  assign mnd       = mag64(nd_r);
  assign one_minus = 64'sd1 - prod_r;
  assign mone      = mag64(one_minus);
  assign gneg      = b_r[WideW-1] && !one_zero_r;

  // Signed truncating and unsigned division on the shared unsigned divider.
  always_comb begin
    div_start = 1'b1;
    div_n     = x_r;
    div_d     = y_r;
    div_neg   = 1'b0;
    case (op)
      OP_GCD_DIV: ;
      OP_SIGN_G: begin
        div_n = ma; div_d = x_r; div_neg = a_r[WideW-1] ^ gneg;
      end
      OP_AN_DONE: begin
        div_n = mb; div_d = x_r; div_neg = b_r[WideW-1] ^ gneg;
      end
      OP_RED_START: begin div_n = mns; div_d = m_r; end
      OP_INV_DIV:   begin div_n = r0_r; div_d = r1_r; end
      OP_COEF_DIV: begin
        div_n = mone; div_d = mnd; div_neg = one_minus[WideW-1] ^ nd_r[WideW-1];
      end
      default: div_start = 1'b0;
    endcase
  end

  assign sq = neg_r ? -$signed(div_q) : $signed(div_q);

  sglb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  // Every product is of two magnitudes below 2^32, so one 32x32 multiplier serves.
  always_comb begin
    mul_x   = '0;
    mul_y   = '0;
    mul_neg = 1'b0;
    case (op)
      OP_LCM_MUL: begin
        mul_x = ma[OpW-1:0]; mul_y = mbn[OpW-1:0];
        mul_neg = a_r[WideW-1] ^ bn_r[WideW-1];
      end
      OP_INV_MUL: begin
        mul_x = div_q[OpW-1:0]; mul_y = mt1[OpW-1:0]; mul_neg = t1_r[WideW-1];
      end
      OP_COEF_MUL: begin
        mul_x = c_r[OpW-1:0]; mul_y = mns[OpW-1:0]; mul_neg = ns_r[WideW-1];
      end
      default: ;
    endcase
  end

  assign mul_p = WideW'(mul_x) * WideW'(mul_y);
  assign mul_s = mul_neg ? -$signed(mul_p) : $signed(mul_p);

  always_ff @(posedge clk) begin
    if (div_start) neg_r <= div_neg;
    case (op)
      OP_LOAD: begin
        a_r    <= WideW'(in_a);
        b_r    <= WideW'(in_b);
        zero_r <= (in_a == '0) && (in_b == '0);
      end
      OP_GCD_INIT: begin
        sel_b_r    <= (ma <= mb);
        one_zero_r <= (ma == '0) || (mb == '0);
        if (ma < mb) begin x_r <= mb; y_r <= ma; end
        else begin x_r <= ma; y_r <= mb; end
      end
      OP_GCD_STEP: begin x_r <= y_r; y_r <= div_r; end
      OP_SIGN_G:   g_r  <= gneg ? -$signed(x_r) : $signed(x_r);
      OP_AN_DONE:  an_r <= sq;
      OP_BN_DONE:  bn_r <= sq;
      OP_LCM_MUL: begin
        prod_r <= mul_s;
        m_r    <= sel_b_r ? man : mbn;
        ns_r   <= sel_b_r ? bn_r : an_r;
        nd_r   <= sel_b_r ? an_r : bn_r;
      end
      OP_LCM_DONE: lcm_r <= (a_r == b_r) ? a_r : prod_r;
      OP_COEF_EASY: begin
        c_r <= '0;
        o_r <= (m_r == 64'd1) ? nd_r : '0;
      end
      OP_RED_DONE: begin
        r0_r <= m_r;
        // C remainder takes the sign of the dividend; fold it into [0, m).
        r1_r <= (ns_r[WideW-1] && div_r != '0) ? m_r - div_r : div_r;
        t0_r <= '0;
        t1_r <= 64'sd1;
      end
      OP_INV_MUL: begin
        prod_r <= mul_s;
        r0_r   <= r1_r;
        r1_r   <= div_r;
      end
      OP_INV_STEP: begin
        t0_r <= t1_r;
        t1_r <= t0_r - prod_r;
      end
      OP_INV_FIX:   c_r    <= t0_r[WideW-1] ? t0_r + $signed(m_r) : t0_r;
      OP_COEF_MUL:  prod_r <= mul_s;
      OP_COEF_DONE: o_r    <= sq;
      OP_FINISH: begin
        if (zero_r) begin
          g_out_r     <= '0;
          lcm_out_r   <= '0;
          alpha_out_r <= '0;
          beta_out_r  <= '0;
        end else begin
          g_out_r     <= g_r[OpW-1:0];
          lcm_out_r   <= lcm_r;
          alpha_out_r <= sel_b_r ? o_r[OpW-1:0] : c_r[OpW-1:0];
          beta_out_r  <= sel_b_r ? c_r[OpW-1:0] : o_r[OpW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign status = '{y_zero: (y_r == '0), r1_zero: (r1_r == '0), div_busy: div_busy,
                    both_zero: zero_r, m_small: (m_r <= 64'd1)};
  assign res_g     = g_out_r;
  assign res_lcm   = lcm_out_r;
  assign res_alpha = alpha_out_r;
  assign res_beta  = beta_out_r;
  assign res_zero  = zero_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sglb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Gcd/lcm/Bezout controller
// Sequences the datapath through Euclid, normalization and the inverse.
// ---------------------------------------------------------------------------
`default_nettype none

module sglb_ctrl
  import sglb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic       out_fire,
  input  wire dp_status_t status,
  output dp_op_t          op,
  output logic            busy,
  output logic            res_valid
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_EUCLID, S_EWAIT, S_AN, S_BN, S_LCM, S_LCM_DONE, S_SELECT,
    S_RED, S_INV_CHK, S_INV_WAIT, S_INV_STEP, S_COEF_MUL, S_COEF_DIV, S_COEF_WAIT,
    S_FINISH, S_DONE
  } state_t;

  state_t state_r;

  // Each wait state is entered right after a divider start, so busy is
  // already high on its first cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE:      if (in_fire) state_r <= S_INIT;
        S_INIT:      state_r <= status.both_zero ? S_FINISH : S_EUCLID;
        S_EUCLID:    state_r <= status.y_zero ? S_AN : S_EWAIT;
        S_EWAIT:     if (!status.div_busy) state_r <= S_EUCLID;
        S_AN:        if (!status.div_busy) state_r <= S_BN;
        S_BN:        if (!status.div_busy) state_r <= S_LCM;
        S_LCM:       state_r <= S_LCM_DONE;
        S_LCM_DONE:  state_r <= S_SELECT;
        S_SELECT:    state_r <= status.m_small ? S_FINISH : S_RED;
        S_RED:       if (!status.div_busy) state_r <= S_INV_CHK;
        S_INV_CHK:   state_r <= status.r1_zero ? S_COEF_MUL : S_INV_WAIT;
        S_INV_WAIT:  if (!status.div_busy) state_r <= S_INV_STEP;
        S_INV_STEP:  state_r <= S_INV_CHK;
        S_COEF_MUL:  state_r <= S_COEF_DIV;
        S_COEF_DIV:  state_r <= S_COEF_WAIT;
        S_COEF_WAIT: if (!status.div_busy) state_r <= S_FINISH;
        S_FINISH: begin
          state_r   <= S_DONE;
          res_valid <= 1'b1;
        end
        S_DONE: begin
          if (out_fire) begin
            res_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default:     state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    op = OP_NONE;
    case (state_r)
      S_IDLE:      op = in_fire ? OP_LOAD : OP_NONE;
      S_INIT:      op = OP_GCD_INIT;
      S_EUCLID:    op = status.y_zero ? OP_SIGN_G : OP_GCD_DIV;
      S_EWAIT:     op = !status.div_busy ? OP_GCD_STEP : OP_NONE;
      S_AN:        op = !status.div_busy ? OP_AN_DONE : OP_NONE;
      S_BN:        op = !status.div_busy ? OP_BN_DONE : OP_NONE;
      S_LCM:       op = OP_LCM_MUL;
      S_LCM_DONE:  op = OP_LCM_DONE;
      S_SELECT:    op = status.m_small ? OP_COEF_EASY : OP_RED_START;
      S_RED:       op = !status.div_busy ? OP_RED_DONE : OP_NONE;
      S_INV_CHK:   op = status.r1_zero ? OP_INV_FIX : OP_INV_DIV;
      S_INV_WAIT:  op = !status.div_busy ? OP_INV_MUL : OP_NONE;
      S_INV_STEP:  op = OP_INV_STEP;
      S_COEF_MUL:  op = OP_COEF_MUL;
      S_COEF_DIV:  op = OP_COEF_DIV;
      S_COEF_WAIT: op = !status.div_busy ? OP_COEF_DONE : OP_NONE;
      S_FINISH:    op = OP_FINISH;
      default:     op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/signed_gcd_lcm_bezout_unit.sv =====
// ---------------------------------------------------------------------------
// Signed gcd / lcm / Bezout unit
// Top level: controller, datapath and the two stream channels.
// ---------------------------------------------------------------------------
// Usage: a request on the in channel carries operand_a and operand_b. One
// result request follows on the out channel with gcd_value, lcm_value, alpha,
// beta and zero_error. One request is worked at a time; the in channel is
// ready only when the unit is idle, and the next request can be taken in the
// cycle after the result is delivered.
// The run time is dominated by the shared radix-2 divider, which serves each
// Euclid step, the normalizations and, when the coefficients need a modular
// inverse, the reduction, each inverse step and the final coefficient. Each
// chain has at most about 46 steps. Two zero operands skip straight to the
// result.
// A synchronous reset drops any request in flight and clears out valid.
// When the receiver stalls, the result is held in registers and no new
// request is taken until it is delivered.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_gcd_lcm_bezout_unit
  import sglb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sglb_in_if.sink   in_ch,
  sglb_out_if.source out_ch
);

  dp_op_t     op;
  dp_status_t status;
  logic       busy, res_valid;

  assign in_ch.ready = !busy;

  sglb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_ch.valid && in_ch.ready),
    .out_fire(out_ch.valid && out_ch.ready), .status(status), .op(op),
    .busy(busy), .res_valid(res_valid)
  );

  sglb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .in_a(in_ch.operand_a), .in_b(in_ch.operand_b), .status(status),
    .res_g(out_ch.gcd_value), .res_lcm(out_ch.lcm_value), .res_alpha(out_ch.alpha),
    .res_beta(out_ch.beta), .res_zero(out_ch.zero_error)
  );

  assign out_ch.valid = res_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/sglb_checker.sv =====
// ---------------------------------------------------------------------------
// Gcd/lcm/Bezout port checker
// Watches the top-level channels for ordering and hold rules.
// ---------------------------------------------------------------------------
`default_nettype none

module sglb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic zero_error,
  input wire logic [31:0] gcd_value
);

  // A request is never taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A result is never offered in the cycle right after a request is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // An error result carries a zero gcd.
  a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && zero_error) |-> (gcd_value == '0)) else $error("bad error gcd");

  // Result valid holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind signed_gcd_lcm_bezout_unit sglb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .zero_error(out_ch.zero_error),
  .gcd_value(out_ch.gcd_value)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Signed gcd/lcm/Bezout unit testbench
// Sends operand pairs over the valid/ready input channel and compares each
// result with an in-bench prediction of gcd, lcm and Bezout coefficients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sglb_pkg::*;

  localparam int CycleLimit = 30000000;
  localparam int LongHold   = 4000;
  localparam int MinInt     = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] gcd_value;
    logic signed [63:0] lcm_value;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic               zero_error;
  } gcd_result_t;

  logic clk;
  logic rst_n;

  sglb_in_if  in_ch ();
  sglb_out_if out_ch ();

  signed_gcd_lcm_bezout_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  gcd_result_t pending_results[$];
  int          error_count;
  int          cycle_count;
  int          burst_left;
  int          hold_seq;
  int          hold_seen;
  int          hold_left;
  int          stall_mode;
  int          stall_phase;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Inverse of x modulo m, m > 1 and x coprime to m, in [0, m).
  function automatic longint inverse_mod(longint x, longint m);
    longint r0, r1, t0, t1, q, rt, tt;
    r0 = m;
    r1 = ((x % m) + m) % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      tt = t0 - q * t1;
      r0 = r1;
      r1 = rt;
      t0 = t1;
      t1 = tt;
    end
    t0 = t0 % m;
    if (t0 < 0) t0 += m;
    return t0;
  endfunction

  function automatic gcd_result_t compute_gcd_lcm(logic signed [31:0] op_a,
                                                  logic signed [31:0] op_b);
    gcd_result_t r;
    longint a, b, x, y, t, g, an, bn, lcm, al, be, m;
    a  = op_a;
    b  = op_b;
    r  = '0;
    al = 0;
    be = 0;
    if (a == 0 && b == 0) begin
      r.zero_error = 1'b1;
      return r;
    end
    x = (a < 0) ? -a : a;
    y = (b < 0) ? -b : b;
    if (x < y) begin
      t = x; x = y; y = t;
    end
    if (y == 0) begin
      g = x;
    end else begin
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      g = (b < 0) ? -x : x;
    end
    an  = a / g;
    bn  = b / g;
    lcm = (a == b) ? a : a * bn;
    if (((a < 0) ? -a : a) <= ((b < 0) ? -b : b)) begin
      m = (an < 0) ? -an : an;
      if (m == 1) begin
        al = an;
      end else if (m > 1) begin
        be = inverse_mod(bn, m);
        al = (1 - be * bn) / an;
      end
    end else begin
      m = (bn < 0) ? -bn : bn;
      if (m == 1) begin
        be = bn;
      end else if (m > 1) begin
        al = inverse_mod(an, m);
        be = (1 - al * an) / bn;
      end
    end
    r.gcd_value = g[31:0];
    r.lcm_value = lcm;
    r.alpha     = al[31:0];
    r.beta      = be[31:0];
    return r;
  endfunction

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    gcd_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: gcd=%0d lcm=%0d", out_ch.gcd_value, out_ch.lcm_value);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.gcd_value !== exp_r.gcd_value) begin
          $error("gcd_value expected %0d got %0d", exp_r.gcd_value, out_ch.gcd_value);
          error_count++;
        end
        if (out_ch.lcm_value !== exp_r.lcm_value) begin
          $error("lcm_value expected %0d got %0d", exp_r.lcm_value, out_ch.lcm_value);
          error_count++;
        end
        if (out_ch.alpha !== exp_r.alpha) begin
          $error("alpha expected %0d got %0d", exp_r.alpha, out_ch.alpha);
          error_count++;
        end
        if (out_ch.beta !== exp_r.beta) begin
          $error("beta expected %0d got %0d", exp_r.beta, out_ch.beta);
          error_count++;
        end
        if (out_ch.zero_error !== exp_r.zero_error) begin
          $error("zero_error expected %0b got %0b", exp_r.zero_error, out_ch.zero_error);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
      stall_phase <= (stall_phase + 1) % 97;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        2:       out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (stall_phase % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one request; valid stays high within a burst.
  task automatic send_pair(input logic signed [31:0] op_a, input logic signed [31:0] op_b);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= op_a;
    in_ch.operand_b <= op_b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_results.push_back(compute_gcd_lcm(op_a, op_b));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_operand();
    int sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       v = 0;
      1:       v = $urandom_range(1, 16);
      2:       v = MinInt;
      3:       v = $urandom_range(1, 1000);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v != MinInt) v = -v;
    return v;
  endfunction

  task automatic test_directed();
    logic signed [31:0] da[$];
    logic signed [31:0] db[$];
    da = '{0, 0, 5, 0, -5, 1, 12, -12, 12, 18, 7, -7, 2147483647, -2147483647,
           MinInt, MinInt, 6, MinInt, 1, 3, -1, 10, 196608, 2147483647, 0};
    db = '{0, 5, 0, -5, 0, 1, 18, 18, -18, 12, 7, -7, 2147483646, 2147483647,
           MinInt, 6, MinInt, 0, -2147483647, 1, 10, -1, 327680, 1, MinInt};
    foreach (da[i]) send_pair(da[i], db[i]);
    stop_sending();
  endtask

  task automatic test_random(input int count);
    logic signed [31:0] a, b, f;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: begin
          // Shared factor, so the gcd is large and normalization matters.
          f = $urandom_range(2, 70000);
          a = f * $signed($urandom_range(0, 30000)) * ($urandom_range(0, 1) ? -1 : 1);
          b = f * $signed($urandom_range(0, 30000)) * ($urandom_range(0, 1) ? -1 : 1);
        end
        1: begin
          a = random_operand();
          b = $urandom_range(0, 1) ? a : -a;
        end
        default: begin
          a = random_operand();
          b = random_operand();
        end
      endcase
      send_pair(a, b);
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_seq++;
    repeat (6) send_pair($urandom, $urandom);
    stop_sending();
  endtask

  task automatic test_drain_pause();
    wait_results_drained();
    repeat (4) send_pair(random_operand(), random_operand());
    stop_sending();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    clk             = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    burst_left      = 0;
    hold_seq        = 0;
    hold_seen       = 0;
    hold_left       = 0;
    stall_mode      = 0;
    stall_phase     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(340);
    test_drain_pause();
    test_random(340);

    wait_results_drained();
    repeat (8000) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
